### src/dtp_pkg.sv
// Package for the duration text parser: byte classes, queue item type,
// parser phases and the unit word tables. No dependencies.
package dtp_pkg;

    localparam int NUM_UNITS = 10;
    localparam int UNIT_STR_W = 12 * 8;
    localparam int Q_AW = 2;
    localparam int Q_DEPTH = 1 << Q_AW;
    localparam logic [9:0] ALL_UNITS = 10'h3FF;
    localparam logic [31:0] MS_PER_SEC = 32'd1000;
    localparam logic [31:0] MAX_DAYS = 32'd24;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [3:0] UNIT_DAYS = 4'd0;

    typedef enum logic [2:0] {
        CLS_END,
        CLS_SPACE,
        CLS_DIGIT,
        CLS_ALPHA,
        CLS_PUNCT,
        CLS_OTHER
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        logic [7:0] sym;
    } item_t;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_NUM,
        PH_PUNCT1,
        PH_SPACE0,
        PH_WORD,
        PH_SPACE2,
        PH_PUNCT2
    } phase_t;

    localparam logic [UNIT_STR_W-1:0] UNIT_STR [NUM_UNITS] = '{
        UNIT_STR_W'("days"), UNIT_STR_W'("hours"), UNIT_STR_W'("minutes"),
        UNIT_STR_W'("mins"), UNIT_STR_W'("seconds"), UNIT_STR_W'("secs"),
        UNIT_STR_W'("milliseconds"), UNIT_STR_W'("millisecs"),
        UNIT_STR_W'("mseconds"), UNIT_STR_W'("msecs")
    };

    localparam logic [3:0] UNIT_LEN [NUM_UNITS] = '{
        4'd4, 4'd5, 4'd7, 4'd4, 4'd7, 4'd4, 4'd12, 4'd9, 4'd8, 4'd5
    };

    localparam logic [31:0] UNIT_MULT [NUM_UNITS] = '{
        32'd86400000, 32'd3600000, 32'd60000, 32'd60000, 32'd1000,
        32'd1000, 32'd1, 32'd1, 32'd1, 32'd1
    };

    // Character of a unit word at a position; zero past its end.
    function automatic logic [7:0] unit_char(input logic [3:0] u, input logic [3:0] pos);
        int sh;
        logic [7:0] c;
        c = 8'h00;
        sh = 0;
        if (pos < UNIT_LEN[u]) begin
            sh = 8 * (int'(UNIT_LEN[u]) - 1 - int'(pos));
            c = UNIT_STR[u][sh +: 8];
        end
        return c;
    endfunction

endpackage

### src/dtp_front.sv
// Front part of the duration text parser: accepts text bytes and sorts
// them into character classes for the queue. Depends on dtp_pkg.
module dtp_front
    import dtp_pkg::*;
(
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // ch
    input  logic       q_ready,
    output logic       q_push,
    output item_t      q_item
);

    logic [7:0] ch;
    logic       is_space;
    logic       is_digit;
    logic       is_alpha;
    logic       is_punct;

    assign ch = s_axis_tdata;
    assign is_space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
    assign is_digit = (ch >= 8'h30 && ch <= 8'h39);
    assign is_alpha = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    assign is_punct = ((ch >= 8'h21 && ch <= 8'h2F) || (ch >= 8'h3A && ch <= 8'h40) ||
                       (ch >= 8'h5B && ch <= 8'h60) || (ch >= 8'h7B && ch <= 8'h7E)) &&
                      (ch != CH_DASH);

    always_comb
    begin
        q_item.sym = ch;
        priority if (ch == CH_NUL)
        begin
            q_item.cls = CLS_END;
        end
        else if (is_space)
        begin
            q_item.cls = CLS_SPACE;
        end
        else if (is_digit)
        begin
            q_item.cls = CLS_DIGIT;
            q_item.sym = ch - CH_ZERO;
        end
        else if (is_alpha)
        begin
            q_item.cls = CLS_ALPHA;
            q_item.sym = ch | CASE_BIT;
        end
        else if (is_punct)
        begin
            q_item.cls = CLS_PUNCT;
        end
        else
        begin
            q_item.cls = CLS_OTHER;
        end
    end

    assign s_axis_tready = q_ready;
    assign q_push = s_axis_tvalid && q_ready;

endmodule

### src/dtp_queue.sv
// Short queue of classified bytes between the front and back parts of the
// duration text parser. Depends on dtp_pkg.
module dtp_queue
    import dtp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  ready,
    input  logic  pop,
    output logic  valid,
    output item_t head
);

    item_t             mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW:0]     count_reg;
    logic [Q_AW:0]     count_next;

    assign ready = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign valid = (count_reg != '0);
    assign head = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/dtp_back.sv
// Back part of the duration text parser: runs the grammar over classified
// bytes, accumulates milliseconds and holds the result. Depends on dtp_pkg.
module dtp_back
    import dtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        res_ok,
    output logic [31:0] res_ms
);

    phase_t      phase_reg, phase_next;
    logic [31:0] number_reg, number_next;
    logic [31:0] total_reg, total_next;
    logic        valid_reg, valid_next;
    logic        failed_reg, failed_next;
    logic [3:0]  wlen_reg, wlen_next;
    logic [9:0]  mask_reg, mask_next;
    logic        out_valid_reg, out_valid_next;
    logic        res_ok_reg, res_ok_next;
    logic [31:0] res_ms_reg, res_ms_next;

    logic        is_end;
    logic [31:0] dig_base;
    logic [35:0] dig_sum;
    logic        lstart;
    logic [3:0]  lpos;
    logic [9:0]  lmask_base;
    logic [9:0]  letter_mask;
    logic [3:0]  letter_len;
    logic [3:0]  close_sel;
    logic        close_found;
    logic [31:0] mult_val;
    logic [31:0] product;
    logic        add_en;
    logic        ok_v;
    logic        fin;
    phase_t      ph;

    assign is_end = (q_item.cls == CLS_END);
    assign q_pop = q_valid && (!is_end || !out_valid_reg || res_ready);

    assign dig_base = (phase_reg == PH_NUM) ? number_reg : '0;
    assign dig_sum = ({4'b0, dig_base} << 3) + ({4'b0, dig_base} << 1) +
                     {32'b0, q_item.sym[3:0]};

    assign lstart = (phase_reg != PH_WORD);
    assign lpos = lstart ? 4'd0 : wlen_reg;
    assign lmask_base = lstart ? ALL_UNITS : mask_reg;
    assign letter_len = (lpos == 4'd15) ? lpos : lpos + 4'd1;

    always_comb
    begin
        for (int i = 0; i < NUM_UNITS; i++)
        begin
            letter_mask[i] = lmask_base[i] && (unit_char(4'(i), lpos) == q_item.sym);
        end
    end

    always_comb
    begin
        close_sel = '0;
        close_found = 1'b0;
        for (int i = NUM_UNITS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                close_sel = 4'(i);
                close_found = 1'b1;
            end
        end
    end

    assign mult_val = (phase_reg == PH_WORD) ? UNIT_MULT[close_sel] : MS_PER_SEC;
    assign product = number_reg * mult_val;

    always_comb
    begin
        phase_next = phase_reg;
        number_next = number_reg;
        total_next = total_reg;
        valid_next = valid_reg;
        failed_next = failed_reg;
        wlen_next = wlen_reg;
        mask_next = mask_reg;
        add_en = 1'b0;
        ok_v = 1'b0;
        ph = phase_reg;
        fin = failed_reg;

        if (!fin && ph == PH_LEAD)
        begin
            if (q_item.cls == CLS_DIGIT)
            begin
                number_next = dig_sum[31:0];
                ph = PH_NUM;
            end
            else if (q_item.cls != CLS_SPACE)
            begin
                failed_next = 1'b1;
            end
            fin = 1'b1;
        end
        if (!fin && ph == PH_NUM)
        begin
            if (q_item.cls == CLS_DIGIT)
            begin
                if (dig_sum[35:32] != 4'd0)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    number_next = dig_sum[31:0];
                end
                fin = 1'b1;
            end
            else
            begin
                ph = PH_PUNCT1;
            end
        end
        if (!fin && ph == PH_PUNCT1)
        begin
            if (q_item.cls == CLS_PUNCT)
            begin
                fin = 1'b1;
            end
            else if (q_item.cls == CLS_ALPHA)
            begin
                ph = PH_WORD;
                wlen_next = letter_len;
                mask_next = letter_mask;
                fin = 1'b1;
            end
            else
            begin
                ph = PH_SPACE0;
            end
        end
        if (!fin && ph == PH_SPACE0)
        begin
            if (q_item.cls != CLS_SPACE)
            begin
                if (is_end)
                begin
                    add_en = 1'b1;
                    ok_v = 1'b1;
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
            fin = 1'b1;
        end
        if (!fin && ph == PH_WORD)
        begin
            if (q_item.cls == CLS_ALPHA)
            begin
                wlen_next = letter_len;
                mask_next = letter_mask;
                fin = 1'b1;
            end
            else
            begin
                if (close_found)
                begin
                    if (close_sel == UNIT_DAYS && number_reg > MAX_DAYS)
                    begin
                        failed_next = 1'b1;
                        fin = 1'b1;
                    end
                    else
                    begin
                        add_en = 1'b1;
                    end
                end
                else
                begin
                    valid_next = 1'b0;
                end
                if (!fin)
                begin
                    ph = PH_SPACE2;
                end
            end
        end
        if (!fin && ph == PH_SPACE2)
        begin
            if (q_item.cls == CLS_SPACE)
            begin
                fin = 1'b1;
            end
            else
            begin
                ph = PH_PUNCT2;
            end
        end
        if (!fin && ph == PH_PUNCT2)
        begin
            if (q_item.cls != CLS_PUNCT)
            begin
                if (is_end)
                begin
                    ok_v = valid_next;
                end
                else if (q_item.cls == CLS_DIGIT)
                begin
                    number_next = dig_sum[31:0];
                    ph = PH_NUM;
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
            fin = 1'b1;
        end
        if (!fin)
        begin
            failed_next = 1'b1;
        end

        phase_next = ph;
        if (add_en)
        begin
            total_next = total_reg + product;
        end

        res_ok_next = ok_v && !failed_next;
        res_ms_next = total_next;

        if (is_end)
        begin
            phase_next = PH_LEAD;
            number_next = '0;
            total_next = '0;
            valid_next = 1'b1;
            failed_next = 1'b0;
            wlen_next = '0;
            mask_next = ALL_UNITS;
        end

        if (q_pop && is_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            number_reg <= '0;
            total_reg <= '0;
            valid_reg <= 1'b1;
            failed_reg <= 1'b0;
            wlen_reg <= '0;
            mask_reg <= ALL_UNITS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg <= phase_next;
                number_reg <= number_next;
                total_reg <= total_next;
                valid_reg <= valid_next;
                failed_reg <= failed_next;
                wlen_reg <= wlen_next;
                mask_reg <= mask_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && is_end)
        begin
            res_ok_reg <= res_ok_next;
            res_ms_reg <= res_ms_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_ok = res_ok_reg;
    assign res_ms = res_ms_reg;

`ifndef SYNTHESIS
    a_failed_holds_total: assert property (@(posedge clk) disable iff (!rst_n)
        (failed_reg && q_pop && !is_end) |=> $stable(total_reg))
        else $error("Total changed after a failure.");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && is_end) |=> (phase_reg == PH_LEAD && out_valid_reg &&
                               !failed_reg && total_reg == '0))
        else $error("Parser did not restart after the end of a text.");

    a_failed_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && is_end && failed_reg) |=> !res_ok_reg)
        else $error("Failed text reported as valid.");
`endif

endmodule

### src/duration_text_parser_core.sv
// Duration text parser: one text byte per request in, one result per NUL out.
// Throughput is one byte per cycle while the queue has room; the back part's
// multiply-accumulate path handles one byte each cycle unless a result waits. The
// NUL is queued, and the back part registers the result when it pops that byte.
// Input stalls only when a result waits and the four-entry queue has filled behind it.
// The reset is asynchronous and active low; it empties the queue and clears the parser.
module duration_text_parser_core
    import dtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // ok, duration_ms, zero padding
);

    logic        q_ready;
    logic        q_push;
    item_t       q_in;
    logic        q_pop;
    logic        q_valid;
    item_t       q_head;
    logic        res_ok;
    logic [31:0] res_ms;

    dtp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    dtp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    dtp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_ok    (res_ok),
        .res_ms    (res_ms)
    );

    assign m_axis_tdata = {7'b0, res_ms, res_ok};

endmodule
